// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the keyframe interpolator RTL.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication every clock edge outside reset.
`define KFI_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define KFI_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/kfi_pkg.sv =====
// Package for the keyframe interpolator: payload types, constants, opcodes.
// No dependencies.
`timescale 1ns / 1ps
package kfi_pkg;
	localparam int MAX_KEYS_DEF = 32;
	localparam int CHANNELS_DEF = 10;
	localparam int POSE_FIELDS = 10;
	localparam int STEP_W = 12;
	localparam logic [STEP_W-1:0] STEPS_RESET = 12'd90;
	localparam logic signed [31:0] Q_Y_RESET = 32'sh0002_8000;
	localparam logic signed [31:0] Q_Z_RESET = 32'shFFFC_8000;

	typedef enum logic [1:0] {
		KIND_SET = 2'd0,
		KIND_CAPTURE = 2'd1,
		KIND_TOGGLE = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_z;
		logic signed [31:0] knee_left;
		logic signed [31:0] body_turn;
		logic signed [31:0] right_arm_z;
		logic signed [31:0] left_arm_z;
		logic signed [31:0] right_arm_x;
		logic signed [31:0] left_arm_x;
		logic signed [31:0] waist;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_pose_x;
		logic signed [31:0] out_pose_y;
		logic signed [31:0] out_pose_z;
		logic signed [31:0] out_knee_left;
		logic signed [31:0] out_body_turn;
		logic signed [31:0] out_right_arm_z;
		logic signed [31:0] out_left_arm_z;
		logic signed [31:0] out_right_arm_x;
		logic signed [31:0] out_left_arm_x;
		logic signed [31:0] out_waist;
		logic playing;
	} rsp_t;

	// Lane control from the sequencer.
	typedef struct packed {
		logic div_start;
		logic acc_en;
		logic load_en;
	} lane_ctl_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v > 33'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -33'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage

// ===== rtl/keyframe_linear_interpolator_top.sv =====
// Top level of the keyframe interpolator: sequencer, channel lanes, result merge.
// Depends on kfi_pkg, kfi_seq, kfi_lane.
//  channel | handshake          | payload
//  request | start / busy       | req (req_t)
//  result  | done strobe        | rsp (rsp_t)
//  config  | cfg_valid/cfg_ready| cfg_data (12 bit)
// Set, capture, a toggle that does not restart, plain ticks and the tick that ends playback go from IDLE to DONE.
// Restart and segment change pass through the accept cycle in IDLE, key RAM
// reads in RDA, RDB and LDB, the divider run in DIV (33 steps in each lane, all lanes in parallel)
// and the result in DONE.
// Reset is asynchronous; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
module keyframe_linear_interpolator_top #(
	parameter int MAX_KEYS = kfi_pkg::MAX_KEYS_DEF,
	parameter int CHANNELS = kfi_pkg::CHANNELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  kfi_pkg::req_t             req,
	output logic                      done,
	output kfi_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [kfi_pkg::STEP_W-1:0] cfg_data
);
	import kfi_pkg::*;
	localparam int AW = $clog2(MAX_KEYS);

	logic [STEP_W-1:0] steps_q, div_val;
	logic set_en, key_we, cap_k0, playing;
	logic [AW-1:0] key_addr;
	lane_ctl_t ctl;
	logic [CHANNELS-1:0] dbusy;
	logic signed [31:0] in_v [POSE_FIELDS];
	logic signed [31:0] pose_v [POSE_FIELDS];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) steps_q <= STEPS_RESET;
		else if (cfg_valid && cfg_ready) steps_q <= cfg_data;
	end
	assign div_val = (steps_q == '0) ? STEP_W'(1) : steps_q;

	assign in_v[0] = req.pose_x;
	assign in_v[1] = req.pose_y;
	assign in_v[2] = req.pose_z;
	assign in_v[3] = req.knee_left;
	assign in_v[4] = req.body_turn;
	assign in_v[5] = req.right_arm_z;
	assign in_v[6] = req.left_arm_z;
	assign in_v[7] = req.right_arm_x;
	assign in_v[8] = req.left_arm_x;
	assign in_v[9] = req.waist;

	kfi_seq #(.MAX_KEYS(MAX_KEYS)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(req.kind), .steps(steps_q),
		.div_busy(|dbusy), .busy(busy), .set_en(set_en), .key_we(key_we),
		.key_addr(key_addr), .cap_k0(cap_k0), .ctl(ctl), .done(done), .playing(playing));

	for (genvar c = 0; c < POSE_FIELDS; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			kfi_lane #(.MAX_KEYS(MAX_KEYS),
				.RESET_VAL(c == 1 ? Q_Y_RESET : (c == 2 ? Q_Z_RESET : 32'sd0))) u_lane (
				.clk(clk), .arst_n(arst_n), .key_we(key_we), .key_addr(key_addr),
				.ctl(ctl), .set_en(set_en), .set_val(in_v[c]),
				.cap_k0(cap_k0), .divisor(div_val), .pose(pose_v[c]),
				.div_busy(dbusy[c]));
		end else begin : g_off
			assign pose_v[c] = '0;
		end
	end

	assign rsp.out_pose_x = pose_v[0];
	assign rsp.out_pose_y = pose_v[1];
	assign rsp.out_pose_z = pose_v[2];
	assign rsp.out_knee_left = pose_v[3];
	assign rsp.out_body_turn = pose_v[4];
	assign rsp.out_right_arm_z = pose_v[5];
	assign rsp.out_left_arm_z = pose_v[6];
	assign rsp.out_right_arm_x = pose_v[7];
	assign rsp.out_left_arm_x = pose_v[8];
	assign rsp.out_waist = pose_v[9];
	assign rsp.playing = playing;
endmodule

// ===== rtl/kfi_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/kfi_lane.sv =====
// One pose channel: key RAM, pose accumulator, serial divider for increment.
// Depends on kfi_pkg and kfi_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kfi_lane #(
	parameter int MAX_KEYS = 32,
	parameter logic signed [31:0] RESET_VAL = 32'sd0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          key_we,
	input  logic [$clog2(MAX_KEYS)-1:0]   key_addr,
	input  kfi_pkg::lane_ctl_t            ctl,
	input  logic                          set_en,
	input  logic signed [31:0]            set_val,
	input  logic                          cap_k0,
	input  logic [kfi_pkg::STEP_W-1:0]    divisor,
	output logic signed [31:0]            pose,
	output logic                          div_busy
);
	import kfi_pkg::*;
	logic signed [31:0] key_rd;
	logic signed [31:0] key_a_q, pose_q, inc_q;
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic [33:0] trial;

	kfi_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_ram (
		.clk(clk), .we(key_we), .addr(key_addr), .wdata(pose_q), .rdata(key_rd));

	assign trial = {rem_q, quo_q[32]} - {22'd0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q <= RESET_VAL;
			inc_q <= '0;
			cnt_q <= '0;
			key_a_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (cap_k0) key_a_q <= key_rd;
			if (set_en) pose_q <= set_val;
			else if (ctl.load_en) pose_q <= key_rd;
			else if (ctl.acc_en) pose_q <= sat33(33'(pose_q) + 33'(inc_q));
			if (ctl.div_start) begin
				neg_q <= $signed(33'(key_rd) - 33'(key_a_q)) < 0;
				quo_q <= $signed(33'(key_rd) - 33'(key_a_q)) < 0
					? 33'(33'(key_a_q) - 33'(key_rd)) : 33'(33'(key_rd) - 33'(key_a_q));
				rem_q <= '0;
				cnt_q <= 6'd33;
			end else if (cnt_q != '0) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], quo_q[32]};
					quo_q <= {quo_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					inc_q <= sat33(33'(trial[33] ?
						(neg_q ? -$signed({1'b0, quo_q[31:0], 1'b0}) : $signed({1'b0, quo_q[31:0], 1'b0})) :
						(neg_q ? -$signed({1'b0, quo_q[31:0], 1'b1}) : $signed({1'b0, quo_q[31:0], 1'b1}))));
				end
			end
		end
	end
	assign pose = pose_q;
	assign div_busy = (cnt_q != '0);

	`KFI_ASSERT_NXT(a_div_start, clk, arst_n, ctl.div_start, cnt_q == 6'd33)
	`KFI_ASSERT_IMP(a_no_overlap, clk, arst_n, ctl.acc_en, cnt_q == '0)
	`KFI_ASSERT_IMP(a_set_excl, clk, arst_n, set_en, !ctl.load_en && !ctl.div_start)
endmodule

// ===== rtl/kfi_seq.sv =====
// Sequencer: decodes requests, walks key RAM reads and divider runs, issues result.
// Depends on kfi_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kfi_seq #(
	parameter int MAX_KEYS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  kind,
	input  logic [kfi_pkg::STEP_W-1:0]  steps,
	input  logic                        div_busy,
	output logic                        busy,
	output logic                        set_en,
	output logic                        key_we,
	output logic [$clog2(MAX_KEYS)-1:0] key_addr,
	output logic                        cap_k0,
	output kfi_pkg::lane_ctl_t          ctl,
	output logic                        done,
	output logic                        playing
);
	import kfi_pkg::*;
	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDA  = 6'b000010,
		ST_RDB  = 6'b000100,
		ST_LDB  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t st_q;
	logic [CW-1:0] kc_q;
	logic [AW-1:0] seg_q, addr_q;
	logic [STEP_W-1:0] sc_q;
	logic play_q, restart_q, wait_q;
	logic kind_cap_q;

	assign busy = (st_q != ST_IDLE);
	assign key_addr = addr_q;
	assign playing = play_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			kc_q <= '0;
			seg_q <= '0;
			addr_q <= '0;
			sc_q <= '0;
			play_q <= 1'b0;
			restart_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_DONE;
						unique case (kind_t'(kind))
							KIND_SET: ;
							KIND_CAPTURE: begin
								if (kc_q < CW'(MAX_KEYS)) begin
									addr_q <= AW'(kc_q);
									kc_q <= kc_q + CW'(1);
								end
							end
							KIND_TOGGLE: begin
								if (!play_q && kc_q >= CW'(2)) begin
									seg_q <= '0;
									sc_q <= '0;
									addr_q <= '0;
									restart_q <= 1'b1;
									st_q <= ST_RDA;
								end else play_q <= 1'b0;
							end
							KIND_TICK: begin
								if (play_q) begin
									if (sc_q >= steps) begin
										if ((CW+1)'(seg_q) + (CW+1)'(3) > (CW+1)'(kc_q)) begin
											seg_q <= '0;
											play_q <= 1'b0;
										end else begin
											seg_q <= seg_q + AW'(1);
											addr_q <= seg_q + AW'(1);
											sc_q <= '0;
											restart_q <= 1'b0;
											st_q <= ST_RDA;
										end
									end else sc_q <= sc_q + STEP_W'(1);
								end
							end
						endcase
					end
				end
				ST_RDA: begin
					addr_q <= addr_q + AW'(1);
					st_q <= ST_RDB;
				end
				ST_RDB: st_q <= ST_LDB;
				ST_LDB: begin
					st_q <= ST_DIV;
					wait_q <= 1'b1;
				end
				ST_DIV: begin
					wait_q <= 1'b0;
					if (!wait_q && !div_busy) begin
						if (restart_q) play_q <= 1'b1;
						st_q <= ST_DONE;
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Key RAM read latency: address at RDA, data (key A) at RDB; key B at LDB.
	always_comb begin
		set_en = 1'b0;
		key_we = 1'b0;
		cap_k0 = (st_q == ST_RDB);
		ctl = '0;
		done = (st_q == ST_DONE);
		if (st_q == ST_IDLE && start) begin
			unique case (kind_t'(kind))
				KIND_SET: set_en = 1'b1;
				KIND_CAPTURE: key_we = 1'b0;
				KIND_TOGGLE: ;
				KIND_TICK: ctl.acc_en = play_q && (sc_q < steps);
			endcase
		end
		if (st_q == ST_RDB) ctl.load_en = restart_q;
		if (st_q == ST_LDB) ctl.div_start = 1'b1;
		if (st_q == ST_DONE && kind_cap_q) key_we = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kind_cap_q <= 1'b0;
		else if (st_q == ST_IDLE) kind_cap_q <= start && kind_t'(kind) == KIND_CAPTURE
			&& kc_q < CW'(MAX_KEYS);
	end

	`KFI_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(st_q))
	`KFI_ASSERT_NXT(a_done_idle, clk, arst_n, st_q == ST_DONE, st_q == ST_IDLE)
	`KFI_ASSERT_IMP(a_kc_max, clk, arst_n, 1'b1, kc_q <= CW'(MAX_KEYS))
endmodule
